// ===== rtl/blake256_pkg.sv =====
// Shared types, constants and tables for the BLAKE-256 hash engine.
// Depends on nothing; imported by every module of the engine but blake256_g_half.
package blake256_pkg;

   localparam int unsigned ROUND_COUNT_DEF = 14;
   localparam int unsigned ROUND_W         = 4;
   localparam int unsigned SIGMA_ROWS      = 10;

   localparam logic [5:0] PAD_LAST_POS   = 6'd55;
   localparam logic [5:0] BLOCK_LAST_POS = 6'd63;
   localparam logic [7:0] PAD_HEAD       = 8'h80;
   localparam logic [7:0] PAD_TAIL       = 8'h01;
   localparam logic [7:0] PAD_BOTH       = 8'h81;
   localparam logic [2:0] WORD_BYTES     = 3'd4;
   localparam logic [2:0] LAST_INDEX     = 3'd7;
   localparam logic [63:0] BLOCK_BITS    = 64'd512;

   localparam logic [31:0] IV_WORDS [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

   localparam logic [31:0] PI_WORDS [16] = '{
      32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
      32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89,
      32'h452821E6, 32'h38D01377, 32'hBE5466CF, 32'h34E90C6C,
      32'hC0AC29B7, 32'hC97C50DD, 32'h3F84D5B5, 32'hB5470917};

   localparam logic [3:0] SIGMA [10][16] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
      '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
        4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
      '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
        4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
      '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
        4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
      '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
        4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
      '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
        4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
      '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
        4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
      '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
        4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
      '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
        4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
      '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
        4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}};

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic             clear;
      logic             ctr_off;
      logic [63:0]      ctr;
      logic [3:0][31:0] salt;
      logic [2:0]       rd_index;
   } cmp_ctrl_type;

   typedef struct packed {
      logic        done;
      logic [3:0]  msg_index;
      logic [31:0] cv_word;
   } cmp_stat_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_RUN,
      CS_FINAL
   } cmp_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_PAD,
      ST_LEN,
      ST_WAIT,
      ST_OUT
   } eng_state_type;

endpackage

// ===== rtl/blake256_hash_engine.sv =====
// Top level of the salted BLAKE-256 hash engine: byte packer, padder, output.
// Depends on blake256_pkg, blake256_compress.
//
//  port group  | direction | handshake        | carries
//  req_*       | in        | valid / stall    | data_word, byte_count, last
//  rsp_*       | out       | valid / stall    | digest_word, word_index, last_word
//  csr_*       | in        | valid / ready    | salt word index 0..3, 32-bit data
//
// A request packs its valid bytes into the block buffer one byte at a time; a filled
// block is compressed on the single shared half-G unit while req_stall stays high.
// The last request pads byte by byte, compresses once or twice, then shows
// eight digest words in turn, each held while rsp_stall is high.
// Synchronous reset loads the initial chain value and clears the counters;
// salts reset to zero and survive a digest. req_stall stays high until idle.
module blake256_hash_engine #(
   parameter int unsigned ROUND_COUNT = blake256_pkg::ROUND_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  blake256_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output blake256_pkg::rsp_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data
);
   import blake256_pkg::*;

   eng_state_type state_ff, state_in, ret_ff, ret_in;
   logic [31:0] buf_ff [16];
   logic [3:0][31:0] salt_ff;
   logic [31:0] word_ff, word_in;
   logic [2:0]  n_ff, n_in, bidx_ff, bidx_in;
   logic        last_ff, last_in;
   logic [5:0]  fill_ff, fill_in, pos_ff, pos_in;
   logic [63:0] ctr_ff, ctr_in, len_ff, len_in;
   logic        second_ff, second_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   // buffer write port: one byte, or the two length words
   logic        byte_we, len_we;
   logic [5:0]  wr_pos;
   logic [7:0]  wr_byte;

   cmp_ctrl_type ctrl;
   cmp_stat_type status;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   blake256_compress #(.ROUND_COUNT(ROUND_COUNT)) u_cmp (
      .clock(clock), .reset(reset), .ctrl(ctrl),
      .msg_word(buf_ff[status.msg_index]), .status(status)
   );

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      word_in = word_ff;
      n_in = n_ff;
      bidx_in = bidx_ff;
      last_in = last_ff;
      fill_in = fill_ff;
      pos_in = pos_ff;
      ctr_in = ctr_ff;
      len_in = len_ff;
      second_in = second_ff;
      out_idx_in = out_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      byte_we = 1'b0;
      len_we = 1'b0;
      wr_pos = fill_ff;
      wr_byte = 8'h00;
      ctrl.start = 1'b0;
      ctrl.clear = 1'b0;
      ctrl.ctr_off = 1'b0;
      ctrl.ctr = ctr_ff + BLOCK_BITS;
      ctrl.salt = salt_ff;
      ctrl.rd_index = out_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               word_in = req_data.data_word;
               n_in = (req_data.byte_count > WORD_BYTES) ? WORD_BYTES : req_data.byte_count;
               last_in = req_data.last;
               bidx_in = 3'd0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (bidx_ff != n_ff) begin
               // pack one byte, compress as soon as the block is full
               byte_we = 1'b1;
               wr_pos = fill_ff;
               wr_byte = word_ff[{~bidx_ff[1:0], 3'b000} +: 8];
               bidx_in = bidx_ff + 3'd1;
               fill_in = fill_ff + 6'd1;
               if (fill_ff == BLOCK_LAST_POS) begin
                  ctr_in = ctr_ff + BLOCK_BITS;
                  ctrl.start = 1'b1;
                  ret_in = ST_LOAD;
                  state_in = ST_WAIT;
               end
            end else if (last_ff) begin
               len_in = ctr_ff + {55'd0, fill_ff, 3'd0};
               pos_in = fill_ff;
               second_in = 1'b0;
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            byte_we = 1'b1;
            wr_pos = pos_ff;
            if (!second_ff && pos_ff == fill_ff) begin
               wr_byte = (pos_ff == PAD_LAST_POS) ? PAD_BOTH : PAD_HEAD;
            end else begin
               wr_byte = (pos_ff == PAD_LAST_POS) ? PAD_TAIL : 8'h00;
            end
            if (pos_ff == PAD_LAST_POS && (second_ff || fill_ff <= PAD_LAST_POS)) begin
               state_in = ST_LEN;
            end else if (pos_ff == BLOCK_LAST_POS) begin
               // no room for the length: compress, then pad a block of its own
               ctrl.start = 1'b1;
               ctrl.ctr = len_ff;
               second_in = 1'b1;
               pos_in = 6'd0;
               ret_in = ST_PAD;
               state_in = ST_WAIT;
            end else begin
               pos_in = pos_ff + 6'd1;
            end
         end
         ST_LEN: begin
            len_we = 1'b1;
            ctrl.start = 1'b1;
            ctrl.ctr = len_ff;
            ctrl.ctr_off = second_ff || (fill_ff == 6'd0);
            out_idx_in = 3'd0;
            ret_in = ST_OUT;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.done) begin
               state_in = ret_ff;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in.digest_word = status.cv_word;
               rsp_in.word_index = out_idx_ff;
               rsp_in.last_word = (out_idx_ff == LAST_INDEX);
            end else if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (out_idx_ff == LAST_INDEX) begin
                  // drop back to the reset state, salts stay
                  ctrl.clear = 1'b1;
                  fill_in = 6'd0;
                  ctr_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         fill_ff <= 6'd0;
         ctr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         salt_ff <= '0;
         bidx_ff <= 3'd0;
         n_ff <= 3'd0;
         out_idx_ff <= 3'd0;
         second_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         fill_ff <= fill_in;
         ctr_ff <= ctr_in;
         rsp_valid_ff <= rsp_valid_in;
         bidx_ff <= bidx_in;
         n_ff <= n_in;
         out_idx_ff <= out_idx_in;
         second_ff <= second_in;
         if (csr_valid && csr_ready) begin
            salt_ff[csr_index] <= csr_data;
         end
      end
      word_ff <= word_in;
      last_ff <= last_in;
      pos_ff <= pos_in;
      len_ff <= len_in;
      rsp_ff <= rsp_in;
   end

   // block buffer
   always_ff @(posedge clock) begin
      if (byte_we) begin
         buf_ff[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
      end
      if (len_we) begin
         buf_ff[14] <= len_ff[63:32];
         buf_ff[15] <= len_ff[31:0];
      end
   end
endmodule

// ===== rtl/blake256_g_half.sv =====
// One half of the BLAKE-256 G function: add, xor, rotate on one column.
// Depends on nothing outside this file.
module blake256_g_half (
   input  logic [31:0] a,
   input  logic [31:0] b,
   input  logic [31:0] c,
   input  logic [31:0] d,
   input  logic [31:0] mx,
   input  logic        second,
   output logic [31:0] a_out,
   output logic [31:0] b_out,
   output logic [31:0] c_out,
   output logic [31:0] d_out
);
   logic [31:0] a1, dx, d1, c1, bx;

   always_comb begin
      a1 = a + b + mx;
      dx = d ^ a1;
      d1 = second ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
      c1 = c + d1;
      bx = b ^ c1;
      a_out = a1;
      c_out = c1;
      d_out = d1;
      b_out = second ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
   end
endmodule

// ===== rtl/blake256_compress.sv =====
// Compression sequencer: work vector rows, chain value, round counters.
// Depends on blake256_pkg and blake256_g_half.
module blake256_compress #(
   parameter int unsigned ROUND_COUNT = blake256_pkg::ROUND_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  blake256_pkg::cmp_ctrl_type ctrl,
   input  logic [31:0]                msg_word,
   output blake256_pkg::cmp_stat_type status
);
   import blake256_pkg::*;

   typedef logic [3:0][31:0] row_type;

   function automatic row_type rotl(row_type r, logic [1:0] k);
      row_type o;
      for (int i = 0; i < 4; i++) begin
         o[i] = r[2'(i) + k];
      end
      return o;
   endfunction

   cmp_state_type state_ff, state_in;
   row_type a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   row_type ta, tb, tc, td;
   logic [31:0] cv_ff [8];
   logic [31:0] cv_in [8];
   logic        half_ff, half_in;
   logic [2:0]  gidx_ff, gidx_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [3:0]  sig_ff, sig_in;
   logic [31:0] ga, gb, gc, gd, mx;
   logic [3:0]  pi_sel;
   logic        phase_end;
   logic [1:0]  kb, kc, kd;
   logic        cmp_done;

   assign status.msg_index = SIGMA[sig_ff][{gidx_ff, half_ff}];
   assign pi_sel           = SIGMA[sig_ff][{gidx_ff, ~half_ff}];
   assign mx               = msg_word ^ PI_WORDS[pi_sel];
   assign status.cv_word   = cv_ff[ctrl.rd_index];
   assign status.done      = cmp_done;

   blake256_g_half u_g (
      .a(a_ff[0]), .b(b_ff[0]), .c(c_ff[0]), .d(d_ff[0]),
      .mx(mx), .second(half_ff),
      .a_out(ga), .b_out(gb), .c_out(gc), .d_out(gd)
   );

   // column phase ends by skewing rows into diagonal order, diagonal phase unskews
   always_comb begin
      phase_end = (gidx_ff[1:0] == 2'd3);
      kb = phase_end ? (gidx_ff[2] ? 2'd0 : 2'd2) : 2'd1;
      kc = phase_end ? 2'd3 : 2'd1;
      kd = phase_end ? (gidx_ff[2] ? 2'd2 : 2'd0) : 2'd1;
   end

   always_comb begin
      state_in = state_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      cv_in = cv_ff;
      half_in = half_ff;
      gidx_in = gidx_ff;
      round_in = round_ff;
      sig_in = sig_ff;
      cmp_done = 1'b0;
      ta = a_ff; tb = b_ff; tc = c_ff; td = d_ff;
      ta[0] = ga; tb[0] = gb; tc[0] = gc; td[0] = gd;
      case (state_ff)
         CS_IDLE: begin
            if (ctrl.start) begin
               for (int i = 0; i < 4; i++) begin
                  a_in[i] = cv_ff[i];
                  b_in[i] = cv_ff[4 + i];
                  c_in[i] = ctrl.salt[i] ^ PI_WORDS[i];
                  d_in[i] = PI_WORDS[4 + i];
               end
               if (!ctrl.ctr_off) begin
                  d_in[0] = d_in[0] ^ ctrl.ctr[31:0];
                  d_in[1] = d_in[1] ^ ctrl.ctr[31:0];
                  d_in[2] = d_in[2] ^ ctrl.ctr[63:32];
                  d_in[3] = d_in[3] ^ ctrl.ctr[63:32];
               end
               half_in = 1'b0;
               gidx_in = 3'd0;
               round_in = '0;
               sig_in = 4'd0;
               state_in = CS_RUN;
            end
         end
         CS_RUN: begin
            half_in = ~half_ff;
            if (half_ff) begin
               a_in = rotl(ta, 2'd1);
               b_in = rotl(tb, kb);
               c_in = rotl(tc, kc);
               d_in = rotl(td, kd);
               gidx_in = gidx_ff + 3'd1;
               if (gidx_ff == 3'd7) begin
                  round_in = round_ff + 1'b1;
                  sig_in = (sig_ff == 4'(SIGMA_ROWS - 1)) ? 4'd0 : sig_ff + 4'd1;
                  if (round_ff == ROUND_W'(ROUND_COUNT - 1)) begin
                     state_in = CS_FINAL;
                  end
               end
            end else begin
               a_in = ta; b_in = tb; c_in = tc; d_in = td;
            end
         end
         CS_FINAL: begin
            for (int i = 0; i < 4; i++) begin
               cv_in[i]     = cv_ff[i] ^ a_ff[i] ^ c_ff[i] ^ ctrl.salt[i];
               cv_in[4 + i] = cv_ff[4 + i] ^ b_ff[i] ^ d_ff[i] ^ ctrl.salt[i];
            end
            cmp_done = 1'b1;
            state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
      if (ctrl.clear) begin
         cv_in = IV_WORDS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         cv_ff    <= IV_WORDS;
         half_ff  <= 1'b0;
         gidx_ff  <= 3'd0;
         round_ff <= '0;
         sig_ff   <= 4'd0;
      end else begin
         state_ff <= state_in;
         cv_ff    <= cv_in;
         half_ff  <= half_in;
         gidx_ff  <= gidx_in;
         round_ff <= round_in;
         sig_ff   <= sig_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
   end
endmodule

// ===== rtl/blake256_checker.sv =====
// Port-level checks for the BLAKE-256 hash engine, bound to the top level.
// Depends on blake256_pkg and blake256_hash_engine.
module blake256_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input blake256_pkg::req_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input blake256_pkg::rsp_type rsp_data
);
   import blake256_pkg::*;

   // a taken request always keeps the engine busy for the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("engine took a second request back to back");

   // digest words only appear while the engine is busy
   a_no_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("digest word shown while idle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled digest word changed");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_index == LAST_INDEX)))
      else $error("last_word does not match word_index");
endmodule

bind blake256_hash_engine blake256_checker u_chk (.*);
